// ===== rtl/bledc_pkg.sv =====
`default_nettype none
package bledc_pkg;

	localparam int unsigned TICKS_PER_SECOND_DEF = 5;
	localparam logic [6:0]  LOW_PCT_RESET        = 7'd10;
	localparam logic [7:0]  STEADY_TICKS         = 8'd255;

	// Pattern numbers.
	localparam logic [3:0] PAT_CHARGING = 4'd0;
	localparam logic [3:0] PAT_FULL     = 4'd1;
	localparam logic [3:0] PAT_S0       = 4'd2;
	localparam logic [3:0] PAT_S0_LOW   = 4'd3;
	localparam logic [3:0] PAT_S0_ERR   = 4'd4;
	localparam logic [3:0] PAT_S3       = 4'd5;
	localparam logic [3:0] PAT_S5       = 4'd6;
	localparam logic [3:0] PAT_FACTORY  = 4'd7;
	localparam logic [3:0] PAT_NONE     = 4'd8;

	// Charger states.
	localparam logic [2:0] CS_CHARGE     = 3'd0;
	localparam logic [2:0] CS_DISCHARGE  = 3'd1;
	localparam logic [2:0] CS_DISCH_FULL = 3'd2;
	localparam logic [2:0] CS_ERROR      = 3'd3;
	localparam logic [2:0] CS_NEAR_FULL  = 3'd4;
	localparam logic [2:0] CS_IDLE       = 3'd5;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_MANUAL = 1'b1;

	typedef enum logic [1:0] {
		COL_OFF   = 2'd0,
		COL_AMBER = 2'd1,
		COL_WHITE = 2'd2
	} color_t;

	typedef struct packed {
		logic       cmd;
		logic [2:0] chg_state;
		logic       ext_power;
		logic       chipset_on;
		logic       chipset_suspend;
		logic [9:0] charge_tenths;
		logic       force_idle;
		logic       auto_enabled;
		logic [7:0] white_brightness;
		logic [7:0] amber_brightness;
	} item_t;

	// Visible state of the LED block, which is also the result.
	typedef struct packed {
		logic       amber_pin;
		logic       white_pin;
		logic [3:0] pattern;
	} led_status_t;

	function automatic logic [7:0] phase0_len(input logic [3:0] pat, input int unsigned tps);
		logic [7:0] len;
		case (pat)
			PAT_S0_LOW, PAT_S0_ERR, PAT_S3: len = 8'(tps);
			PAT_FACTORY:                    len = 8'(2 * tps);
			default:                        len = STEADY_TICKS;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] phase1_len(input logic [3:0] pat, input int unsigned tps);
		logic [7:0] len;
		case (pat)
			PAT_S0_LOW, PAT_S3: len = 8'(3 * tps);
			PAT_S0_ERR:         len = 8'(tps);
			PAT_FACTORY:        len = 8'(2 * tps);
			default:            len = 8'd0;
		endcase
		return len;
	endfunction

	function automatic color_t phase0_color(input logic [3:0] pat);
		color_t c;
		case (pat)
			PAT_CHARGING, PAT_S0_LOW, PAT_S0_ERR: c = COL_AMBER;
			PAT_FULL, PAT_S0, PAT_S3, PAT_FACTORY: c = COL_WHITE;
			default:                               c = COL_OFF;
		endcase
		return c;
	endfunction

	function automatic color_t phase1_color(input logic [3:0] pat);
		color_t c;
		case (pat)
			PAT_FACTORY: c = COL_AMBER;
			default:     c = COL_OFF;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bledc_pick.sv =====
`default_nettype none
module bledc_pick (
	input  wire bledc_pkg::item_t    item,
	input  wire logic [6:0]          low_pct,
	output logic [3:0]               want
);
	import bledc_pkg::*;

	logic [10:0] tenths_rnd;
	logic [10:0] low_tenths;
	logic        low_batt;

	// Rounded percent below the limit is the same as tenths + 5 below limit * 10.
	assign tenths_rnd = {1'b0, item.charge_tenths} + 11'd5;
	assign low_tenths = 11'(low_pct) * 11'd10;
	assign low_batt   = tenths_rnd < low_tenths;

	always_comb begin
		case (item.chg_state)
			CS_CHARGE: want = PAT_CHARGING;
			CS_DISCHARGE, CS_DISCH_FULL: begin
				if (item.chg_state == CS_DISCH_FULL && item.ext_power)
					want = PAT_FULL;
				else if (item.chipset_on)
					want = low_batt ? PAT_S0_LOW : PAT_S0;
				else
					want = item.chipset_suspend ? PAT_S3 : PAT_S5;
			end
			CS_ERROR: begin
				if (item.chipset_on)
					want = PAT_S0_ERR;
				else
					want = item.chipset_suspend ? PAT_S3 : PAT_S5;
			end
			CS_NEAR_FULL: want = PAT_FULL;
			CS_IDLE:      want = item.force_idle ? PAT_FACTORY : PAT_S0;
			default:      want = PAT_NONE;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/bledc_core.sv =====
`default_nettype none
module bledc_core #(
	parameter int unsigned TICKS_PER_SECOND = bledc_pkg::TICKS_PER_SECOND_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire logic                   step,
	input  wire bledc_pkg::item_t       item,
	input  wire logic [6:0]             low_pct,
	output bledc_pkg::led_status_t      status
);
	import bledc_pkg::*;

	logic [3:0] pattern_q;
	logic [7:0] tick_q;
	logic       amber_q;
	logic       white_q;

	logic [3:0] want;
	logic [3:0] pattern_n;
	logic [7:0] tick_base;
	logic [7:0] tick_n;
	logic [7:0] t0;
	logic [7:0] period;
	logic [7:0] tick_inc;
	color_t     color;
	logic       drive;

	bledc_pick u_pick (
		.item    (item),
		.low_pct (low_pct),
		.want    (want)
	);

	// A new pattern restarts the blink sequence from its first phase.
	always_comb begin
		pattern_n = pattern_q;
		tick_base = tick_q;
		if (item.cmd == CMD_TICK && item.auto_enabled && want != PAT_NONE &&
				want != pattern_q) begin
			pattern_n = want;
			tick_base = 8'd0;
		end
	end

	assign t0       = phase0_len(pattern_n, TICKS_PER_SECOND);
	assign period   = t0 + phase1_len(pattern_n, TICKS_PER_SECOND);
	assign tick_inc = tick_base + 8'd1;

	always_comb begin
		tick_n = tick_q;
		color  = COL_OFF;
		drive  = 1'b0;
		if (item.cmd == CMD_MANUAL) begin
			drive = 1'b1;
			if (item.white_brightness != 8'd0)
				color = COL_WHITE;
			else if (item.amber_brightness != 8'd0)
				color = COL_AMBER;
		end else if (item.auto_enabled) begin
			drive  = 1'b1;
			tick_n = tick_base;
			if (pattern_n != PAT_NONE) begin
				color  = (tick_base < t0) ? phase0_color(pattern_n) : phase1_color(pattern_n);
				tick_n = (tick_inc == period) ? 8'd0 : tick_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PAT_NONE;
			tick_q    <= 8'd0;
			amber_q   <= 1'b1;
			white_q   <= 1'b1;
		end else if (step) begin
			pattern_q <= pattern_n;
			tick_q    <= tick_n;
			if (drive) begin
				amber_q <= (color != COL_AMBER);
				white_q <= (color != COL_WHITE);
			end
		end
	end

	assign status.amber_pin = amber_q;
	assign status.white_pin = white_q;
	assign status.pattern   = pattern_q;

endmodule
`default_nettype wire

// ===== rtl/battery_led_blink_controller.sv =====
// Battery status LED controller for one amber and one white LED (pins active low).
// Input stream: each transaction is either a periodic tick (tuser = 0) carrying the
// charger and chipset status, or a manual brightness set (tuser = 1).
// Ticks step a two-phase blink pattern chosen from the status when automatic control
// is enabled; a manual set drives the pins straight from the brightness values.
// Output stream: one transaction per input transaction, in order, with the pin
// levels and the current pattern number after that item.
// Configuration: cfg_we writes the low-battery percent limit; write only when idle.
// An accepted item waits in the input register until the LED state register, which
// doubles as the result register, can take it. Throughput: one item per cycle while
// m_axis_tready stays high; the two registers give a two-entry path through the block.
// When the receiver stalls, the result holds and one more item can wait in the
// input register before s_axis_tready drops.
// Reset: both LEDs dark, no pattern (8), tick counter zero, low-battery limit 10%,
// both channels empty.
`default_nettype none
module battery_led_blink_controller #(
	parameter int unsigned TICKS_PER_SECOND = bledc_pkg::TICKS_PER_SECOND_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [6:0]  cfg_wdata,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] chg_state, [3] ext_power, [4] chipset_on, [5] chipset_suspend,
	// [15:6] charge_tenths, [16] force_idle, [17] auto_enabled,
	// [25:18] white_brightness, [33:26] amber_brightness, [39:34] zero
	input  wire  [39:0] s_axis_tdata,
	// [0] cmd
	input  wire         s_axis_tuser,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [0] amber_pin, [1] white_pin, [5:2] pattern, [7:6] zero
	output logic [7:0]  m_axis_tdata
);
	import bledc_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        out_valid_q;
	logic [6:0]  low_pct_q;
	logic        step;
	led_status_t status;

	assign step          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_pct_q <= LOW_PCT_RESET;
		end else if (cfg_we) begin
			low_pct_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.cmd              <= s_axis_tuser;
			item_s1.chg_state        <= s_axis_tdata[2:0];
			item_s1.ext_power        <= s_axis_tdata[3];
			item_s1.chipset_on       <= s_axis_tdata[4];
			item_s1.chipset_suspend  <= s_axis_tdata[5];
			item_s1.charge_tenths    <= s_axis_tdata[15:6];
			item_s1.force_idle       <= s_axis_tdata[16];
			item_s1.auto_enabled     <= s_axis_tdata[17];
			item_s1.white_brightness <= s_axis_tdata[25:18];
			item_s1.amber_brightness <= s_axis_tdata[33:26];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The LED state only moves when a result is handed over, so it serves as the
	// result payload directly.
	bledc_core #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (item_s1),
		.low_pct (low_pct_q),
		.status  (status)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, status.pattern, status.white_pin, status.amber_pin};

endmodule
`default_nettype wire
